@@ src/wnni_pkg.sv @@
// shared types and constants for the wormhole network interface
package wnni_pkg;

   localparam int INJECT_DEPTH     = 64;
   localparam int ASSEMBLY_ENTRIES = 4;
   localparam int DELIVERY_DEPTH   = 32;
   localparam int FLIT_BITS        = 32;
   localparam int INJ_AW = (INJECT_DEPTH > 1) ? $clog2(INJECT_DEPTH) : 1;
   localparam int DLV_AW = (DELIVERY_DEPTH > 1) ? $clog2(DELIVERY_DEPTH) : 1;
   localparam int ASM_IW = (ASSEMBLY_ENTRIES > 1) ? $clog2(ASSEMBLY_ENTRIES) : 1;
   localparam int INJ_CW = $clog2(INJECT_DEPTH + 1);
   localparam int DLV_CW = $clog2(DELIVERY_DEPTH + 1);
   localparam int FLIT_SH = $clog2(FLIT_BITS);

   localparam logic [2:0] MODE_SEND   = 3'd0;
   localparam logic [2:0] MODE_TICK   = 3'd1;
   localparam logic [2:0] MODE_CREDIT = 3'd2;
   localparam logic [2:0] MODE_FLIT   = 3'd3;
   localparam logic [2:0] MODE_POP    = 3'd4;

   localparam logic [2:0] KIND_SEND  = 3'd0;
   localparam logic [2:0] KIND_FLIT  = 3'd1;
   localparam logic [2:0] KIND_CRED  = 3'd2;
   localparam logic [2:0] KIND_DLV   = 3'd3;
   localparam logic [2:0] KIND_EMPTY = 3'd4;
   localparam logic [2:0] KIND_ERR   = 3'd5;

   localparam logic [2:0] ERR_DEST     = 3'd1;
   localparam logic [2:0] ERR_CREDIT   = 3'd2;
   localparam logic [2:0] ERR_MISROUTE = 3'd3;
   localparam logic [2:0] ERR_EJECT    = 3'd4;
   localparam logic [2:0] ERR_HEAD     = 3'd5;
   localparam logic [2:0] ERR_ORPHAN   = 3'd6;
   localparam logic [2:0] ERR_OCCUPY   = 3'd7;

   localparam logic [2:0] REG_ENDPOINT = 3'd0;
   localparam logic [2:0] REG_NETSIZE  = 3'd1;
   localparam logic [2:0] REG_FPC      = 3'd2;
   localparam logic [2:0] REG_RBUF     = 3'd3;
   localparam logic [2:0] REG_IBUF     = 3'd4;
   localparam logic [2:0] REG_ENABLE   = 3'd5;

   typedef struct packed {
      logic [2:0]  mode;
      logic [8:0]  dest_node;
      logic [11:0] size_bits;
      logic [1:0]  virtual_net;
      logic [6:0]  credit_count;
      logic [15:0] arrive_packet_id;
      logic [7:0]  arrive_dest;
      logic        arrive_head;
      logic        arrive_tail;
      logic [6:0]  arrive_flit_total;
      logic [15:0] packet_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        accepted;
      logic [15:0] out_packet_id;
      logic [7:0]  out_source;
      logic [7:0]  out_dest;
      logic [5:0]  out_flit_index;
      logic [6:0]  out_flit_total;
      logic [15:0] out_tag;
      logic [6:0]  credit_return;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // injection queue entry: pid, dest, index, total, tag
   typedef struct packed {
      logic [15:0] pid;
      logic [7:0]  dest;
      logic [5:0]  index;
      logic [6:0]  total;
      logic [15:0] tag;
   } inj_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [6:0]  flits;
   } dlv_type;

endpackage

@@ src/wnni_ram.sv @@
// generic single-port-write, registered-read ram
module wnni_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ src/wormhole_noc_network_interface.sv @@
// top level of the credit-based wormhole network interface
// Network interface for a wormhole network-on-chip with credit flow control. Send, tick,
// credit, flit and pop items enter on the req channel one at a time. Each item gives zero
// to eight results on the rsp channel, and the last result of an item is marked.
// An accepted send writes its flits into the injection memory (up to 64). A tick sends
// up to 8 flits, each read from the injection memory ahead of time.
// A pop reads the delivery memory, then gives the credit result, then the delivery
// result, or an occupancy error; an empty pop gives an empty result. Credit and flit
// items give no result, or one when they report an error. All results leave through
// one output register. While a result is stalled, the next item is accepted but waits
// before it runs, and a tick pauses between flits. No clearing pass is needed after
// reset, since only memory entries that were written are ever read.
module wormhole_noc_network_interface
   import wnni_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [8:0]  csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_FILL = 6'b000100,
      ST_TICK = 6'b001000,
      ST_POP  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   req_type   item_ff, item_in;

   logic [7:0] endpoint_ff, endpoint_in;
   logic [8:0] netsize_ff, netsize_in;
   logic [3:0] fpc_ff, fpc_in;
   logic [6:0] rbuf_ff, rbuf_in;
   logic [6:0] ibuf_ff, ibuf_in;
   logic       enable_ff, enable_in;

   logic [INJ_AW-1:0] ihead_ff, ihead_in;
   logic [INJ_CW-1:0] ifill_ff, ifill_in;
   logic [6:0]        rcred_ff, rcred_in;
   logic [15:0]       pnum_ff, pnum_in;
   logic [6:0]        efill_ff, efill_in;
   logic [DLV_AW-1:0] dhead_ff, dhead_in;
   logic [DLV_CW-1:0] dfill_ff, dfill_in;

   logic [ASSEMBLY_ENTRIES-1:0] av_ff, av_in;
   logic [15:0] apid_ff [ASSEMBLY_ENTRIES];
   logic [15:0] atag_ff [ASSEMBLY_ENTRIES];
   logic        awr;
   logic [ASM_IW-1:0] awr_idx;

   logic [6:0] count_ff, count_in;
   logic [6:0] idx_ff, idx_in;
   logic [3:0] sent_ff, sent_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic              iwr;
   logic [INJ_AW-1:0] iwaddr, iraddr;
   inj_type           iwdata, irdata;
   logic              dwr;
   logic [DLV_AW-1:0] dwaddr;
   dlv_type           dwdata, drdata;

   wnni_ram #(.WIDTH($bits(inj_type)), .DEPTH(INJECT_DEPTH)) u_inj (
      .clock(clock), .wr_en(iwr), .wr_addr(iwaddr), .wr_data(iwdata),
      .rd_addr(iraddr), .rd_data(irdata));

   wnni_ram #(.WIDTH($bits(dlv_type)), .DEPTH(DELIVERY_DEPTH)) u_dlv (
      .clock(clock), .wr_en(dwr), .wr_addr(dwaddr), .wr_data(dwdata),
      .rd_addr(dhead_ff), .rd_data(drdata));

   logic out_free;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // assembly lookup
   logic found, freeok;
   logic [ASM_IW-1:0] found_idx, free_idx;
   always_comb begin
      found = 1'b0; freeok = 1'b0;
      found_idx = '0; free_idx = '0;
      for (int i = 0; i < ASSEMBLY_ENTRIES; i++) begin
         if (av_ff[i] && apid_ff[i] == item_ff.arrive_packet_id) begin
            if (!found) begin
               found = 1'b1; found_idx = ASM_IW'(i);
            end
         end else if (!av_ff[i] && !freeok) begin
            freeok = 1'b1; free_idx = ASM_IW'(i);
         end
      end
   end

   logic [7:0]  nflits;
   logic [7:0]  cap;
   logic [7:0]  need;
   logic [3:0]  lim;
   logic [7:0]  csum;
   assign nflits = 8'((13'(item_ff.size_bits) + 13'(FLIT_BITS - 1)) >> FLIT_SH);
   assign cap  = (8'(ibuf_ff) < 8'(INJECT_DEPTH)) ? 8'(ibuf_ff) : 8'(INJECT_DEPTH);
   assign need = 8'(ifill_ff) + nflits;
   assign lim  = (fpc_ff > 4'd8) ? 4'd8 : fpc_ff;
   assign csum = 8'(rcred_ff) + 8'(item_ff.credit_count);

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; item_in = item_ff;
      endpoint_in = endpoint_ff; netsize_in = netsize_ff; fpc_in = fpc_ff;
      rbuf_in = rbuf_ff; ibuf_in = ibuf_ff; enable_in = enable_ff;
      ihead_in = ihead_ff; ifill_in = ifill_ff; rcred_in = rcred_ff;
      pnum_in = pnum_ff; efill_in = efill_ff; dhead_in = dhead_ff;
      dfill_in = dfill_ff; av_in = av_ff; count_in = count_ff; idx_in = idx_ff;
      sent_in = sent_ff;
      awr = 1'b0; awr_idx = free_idx;
      iwr = 1'b0;
      iwaddr = INJ_AW'((INJ_CW'(ihead_ff) + ifill_ff) % INJECT_DEPTH);
      iwdata = '0; iraddr = ihead_ff;
      dwr = 1'b0;
      dwaddr = DLV_AW'((DLV_CW'(dhead_ff) + dfill_ff) % DELIVERY_DEPTH);
      dwdata = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;

      if (csr_write) begin
         case (csr_index)
            REG_ENDPOINT: endpoint_in = csr_data[7:0];
            REG_NETSIZE:  netsize_in = csr_data;
            REG_FPC:      fpc_in = csr_data[3:0];
            REG_RBUF: begin
               rbuf_in = csr_data[6:0];
               rcred_in = csr_data[6:0];
            end
            REG_IBUF:     ibuf_in = csr_data[6:0];
            REG_ENABLE:   enable_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait until the previous result has left the output register
            if (out_free) begin
               rsp_in = '0;
               rsp_in.last = 1'b1;
               ret_in = ST_IDLE;
               state_in = ST_IDLE;
               case (item_ff.mode)
                  MODE_SEND: begin
                     state_in = ST_OUT;
                     if (!enable_ff || item_ff.virtual_net != 2'd0) begin
                        rsp_in.kind = KIND_SEND;
                     end else if (item_ff.dest_node >= netsize_ff
                                  || item_ff.dest_node > 9'd255) begin
                        rsp_in.kind = KIND_ERR; rsp_in.error_code = ERR_DEST;
                     end else if (need > cap) begin
                        rsp_in.kind = KIND_SEND;
                     end else begin
                        rsp_in.kind = KIND_SEND;
                        rsp_in.accepted = 1'b1;
                        rsp_in.out_packet_id = pnum_ff;
                        count_in = nflits[6:0]; idx_in = '0;
                        if (nflits != 8'd0) begin
                           state_in = ST_FILL;
                        end else begin
                           pnum_in = pnum_ff + 16'd1;
                        end
                     end
                  end
                  MODE_TICK: begin
                     sent_in = '0;
                     if (lim != 4'd0 && rcred_ff != 7'd0 && ifill_ff != '0) begin
                        state_in = ST_TICK;
                     end
                  end
                  MODE_CREDIT: begin
                     if (csum > 8'(rbuf_ff)) begin
                        rsp_in.kind = KIND_ERR; rsp_in.error_code = ERR_CREDIT;
                        state_in = ST_OUT;
                     end else begin
                        rcred_in = csum[6:0];
                     end
                  end
                  MODE_FLIT: begin
                     rsp_in.kind = KIND_ERR;
                     state_in = ST_OUT;
                     if (item_ff.arrive_dest != endpoint_ff) begin
                        rsp_in.error_code = ERR_MISROUTE;
                     end else if (efill_ff >= rbuf_ff) begin
                        rsp_in.error_code = ERR_EJECT;
                     end else if (item_ff.arrive_head
                                  && (found || (!item_ff.arrive_tail && !freeok))) begin
                        rsp_in.error_code = ERR_HEAD;
                     end else if (item_ff.arrive_tail && !item_ff.arrive_head
                                  && !found) begin
                        rsp_in.error_code = ERR_ORPHAN;
                     end else if (item_ff.arrive_tail
                                  && dfill_ff >= DLV_CW'(DELIVERY_DEPTH)) begin
                        rsp_in.error_code = ERR_EJECT;
                     end else begin
                        state_in = ST_IDLE;
                        efill_in = efill_ff + 7'd1;
                        if (item_ff.arrive_head && !item_ff.arrive_tail) begin
                           awr = 1'b1; av_in[free_idx] = 1'b1;
                        end
                        if (item_ff.arrive_tail) begin
                           dwr = 1'b1;
                           dwdata.flits = item_ff.arrive_flit_total;
                           if (item_ff.arrive_head) begin
                              dwdata.tag = item_ff.packet_tag;
                           end else begin
                              dwdata.tag = atag_ff[found_idx];
                              av_in[found_idx] = 1'b0;
                           end
                           dfill_in = dfill_ff + DLV_CW'(1);
                        end
                     end
                  end
                  MODE_POP: begin
                     if (item_ff.virtual_net != 2'd0 || dfill_ff == '0) begin
                        rsp_in.kind = KIND_EMPTY;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            iwr = 1'b1;
            iwdata.pid = pnum_ff;
            iwdata.dest = item_ff.dest_node[7:0];
            iwdata.index = idx_ff[5:0];
            iwdata.total = count_ff;
            iwdata.tag = (idx_ff == 7'd0) ? item_ff.packet_tag : 16'd0;
            ifill_in = ifill_ff + INJ_CW'(1);
            idx_in = idx_ff + 7'd1;
            if (idx_ff + 7'd1 == count_ff) begin
               pnum_in = pnum_ff + 16'd1;
               state_in = ST_OUT;
               ret_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            // irdata holds entry at ihead_ff, read in the previous cycle
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.kind = KIND_FLIT;
               rsp_in.out_packet_id = irdata.pid;
               rsp_in.out_source = endpoint_ff;
               rsp_in.out_dest = irdata.dest;
               rsp_in.out_flit_index = irdata.index;
               rsp_in.out_flit_total = irdata.total;
               rsp_in.out_tag = irdata.tag;
               ihead_in = INJ_AW'((INJ_CW'(ihead_ff) + INJ_CW'(1)) % INJECT_DEPTH);
               iraddr = ihead_in;
               ifill_in = ifill_ff - INJ_CW'(1);
               rcred_in = rcred_ff - 7'd1;
               sent_in = sent_ff + 4'd1;
               if (sent_ff + 4'd1 == lim || rcred_ff == 7'd1 || ifill_ff == INJ_CW'(1)) begin
                  rsp_in.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POP: begin
            rsp_in = '0;
            if (drdata.flits > efill_ff) begin
               rsp_in.kind = KIND_ERR; rsp_in.error_code = ERR_OCCUPY;
               rsp_in.last = 1'b1;
               ret_in = ST_IDLE;
            end else begin
               rsp_in.kind = KIND_CRED; rsp_in.credit_return = drdata.flits;
               efill_in = efill_ff - drdata.flits;
               dhead_in = DLV_AW'((DLV_CW'(dhead_ff) + DLV_CW'(1)) % DELIVERY_DEPTH);
               dfill_in = dfill_ff - DLV_CW'(1);
               count_in = '0;
               item_in.packet_tag = drdata.tag;
               ret_in = ST_POP;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (ret_ff != ST_POP) begin
                  state_in = ST_IDLE;
               end else if (rsp_valid_ff) begin
                  // credit item taken now, follow with the delivery
                  state_in = ST_IDLE;
                  ret_in = ST_IDLE;
                  rsp_in = '0;
                  rsp_in.kind = KIND_DLV;
                  rsp_in.out_tag = item_ff.packet_tag;
                  rsp_in.last = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ret_ff <= ST_IDLE;
         endpoint_ff <= '0; netsize_ff <= 9'd1; fpc_ff <= 4'd1;
         rbuf_ff <= 7'd32; ibuf_ff <= 7'd64; enable_ff <= 1'b0;
         ihead_ff <= '0; ifill_ff <= '0; rcred_ff <= 7'd32; pnum_ff <= '0;
         efill_ff <= '0; dhead_ff <= '0; dfill_ff <= '0; av_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in;
         endpoint_ff <= endpoint_in; netsize_ff <= netsize_in; fpc_ff <= fpc_in;
         rbuf_ff <= rbuf_in; ibuf_ff <= ibuf_in; enable_ff <= enable_in;
         ihead_ff <= ihead_in; ifill_ff <= ifill_in; rcred_ff <= rcred_in;
         pnum_ff <= pnum_in; efill_ff <= efill_in; dhead_ff <= dhead_in;
         dfill_ff <= dfill_in; av_ff <= av_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; count_ff <= count_in; idx_ff <= idx_in; sent_ff <= sent_in;
      rsp_ff <= rsp_in;
      if (awr) begin
         apid_ff[awr_idx] <= item_ff.arrive_packet_id;
         atag_ff[awr_idx] <= item_ff.packet_tag;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      ifill_ff <= INJ_CW'(INJECT_DEPTH))
      else $error("injection fill above depth");
   a_dlv_bound: assert property (@(posedge clock) disable iff (reset)
      dfill_ff <= DLV_CW'(DELIVERY_DEPTH))
      else $error("delivery fill above depth");
   a_tick_credit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK |-> (rcred_ff != 7'd0 && ifill_ff != '0))
      else $error("flit sent without credit or data");
   a_idle_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !(rsp_valid_ff && !rsp_ff.last && rsp_ff.kind != KIND_FLIT))
      else $error("partial result left at idle");
`endif

endmodule

@@ tb/tb_wormhole_noc_network_interface.sv @@
// testbench for the wormhole network interface: predicts results and checks them in order
`timescale 1ns / 100ps

class wnni_scoreboard;
   wnni_pkg::rsp_type pending[$];
   int errors;

   // interface state and registers
   bit [7:0]  endpoint;
   bit [8:0]  net_size;
   bit [3:0]  fpc;
   bit [6:0]  rbuf;
   bit [6:0]  ibuf;
   bit        en;
   wnni_pkg::inj_type inj_q[$];
   int        credits;
   bit [15:0] next_pid;
   int        eject_fill;
   bit        asm_valid[wnni_pkg::ASSEMBLY_ENTRIES];
   bit [15:0] asm_pid[wnni_pkg::ASSEMBLY_ENTRIES];
   bit [15:0] asm_tag[wnni_pkg::ASSEMBLY_ENTRIES];
   wnni_pkg::dlv_type dlv_q[$];

   function new();
      errors = 0;
      endpoint = 0; net_size = 1; fpc = 1; rbuf = 32; ibuf = 64; en = 0;
      credits = 32; next_pid = 0; eject_fill = 0;
      foreach (asm_valid[i]) asm_valid[i] = 0;
   endfunction

   function void write_reg(bit [2:0] idx, bit [8:0] val);
      case (idx)
         wnni_pkg::REG_ENDPOINT: endpoint = val[7:0];
         wnni_pkg::REG_NETSIZE:  net_size = val;
         wnni_pkg::REG_FPC:      fpc = val[3:0];
         wnni_pkg::REG_RBUF: begin
            rbuf = val[6:0];
            credits = rbuf;
         end
         wnni_pkg::REG_IBUF:     ibuf = val[6:0];
         wnni_pkg::REG_ENABLE:   en = val[0];
         default: ;
      endcase
   endfunction

   function void push(wnni_pkg::rsp_type r);
      pending.insert(pending.size(), r);
   endfunction

   function wnni_pkg::rsp_type blank(bit [2:0] k);
      wnni_pkg::rsp_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   function void note_item(wnni_pkg::req_type q);
      wnni_pkg::rsp_type r;
      wnni_pkg::rsp_type outs[$];
      wnni_pkg::inj_type e;
      wnni_pkg::dlv_type d;
      int cnt, cap, lim, found, freeslot;
      outs = {};
      case (q.mode)
         wnni_pkg::MODE_SEND: begin
            if (!en || q.virtual_net != 0) begin
               outs.insert(outs.size(), blank(wnni_pkg::KIND_SEND));
            end else if (q.dest_node >= net_size || q.dest_node > 255) begin
               r = blank(wnni_pkg::KIND_ERR);
               r.error_code = wnni_pkg::ERR_DEST;
               outs.insert(outs.size(), r);
            end else begin
               cnt = (q.size_bits + 31) / 32;
               cap = ibuf < wnni_pkg::INJECT_DEPTH ? ibuf : wnni_pkg::INJECT_DEPTH;
               if (inj_q.size() + cnt > cap) begin
                  outs.insert(outs.size(), blank(wnni_pkg::KIND_SEND));
               end else begin
                  for (int i = 0; i < cnt; i++) begin
                     e.pid = next_pid;
                     e.dest = q.dest_node[7:0];
                     e.index = 6'(i);
                     e.total = 7'(cnt);
                     e.tag = (i == 0) ? q.packet_tag : 16'd0;
                     inj_q.insert(inj_q.size(), e);
                  end
                  r = blank(wnni_pkg::KIND_SEND);
                  r.accepted = 1;
                  r.out_packet_id = next_pid;
                  outs.insert(outs.size(), r);
                  next_pid++;
               end
            end
         end
         wnni_pkg::MODE_TICK: begin
            lim = fpc > 8 ? 8 : fpc;
            while (outs.size() < lim && credits != 0 && inj_q.size() != 0) begin
               e = inj_q[0];
               inj_q.delete(0);
               r = blank(wnni_pkg::KIND_FLIT);
               r.out_packet_id = e.pid;
               r.out_source = endpoint;
               r.out_dest = e.dest;
               r.out_flit_index = e.index;
               r.out_flit_total = e.total;
               r.out_tag = e.tag;
               outs.insert(outs.size(), r);
               credits--;
            end
         end
         wnni_pkg::MODE_CREDIT: begin
            if (credits + q.credit_count > rbuf) begin
               r = blank(wnni_pkg::KIND_ERR);
               r.error_code = wnni_pkg::ERR_CREDIT;
               outs.insert(outs.size(), r);
            end else begin
               credits += q.credit_count;
            end
         end
         wnni_pkg::MODE_FLIT: begin
            found = -1;
            freeslot = -1;
            r = blank(wnni_pkg::KIND_ERR);
            for (int i = 0; i < wnni_pkg::ASSEMBLY_ENTRIES; i++) begin
               if (asm_valid[i] && asm_pid[i] == q.arrive_packet_id) begin
                  if (found < 0) found = i;
               end else if (!asm_valid[i] && freeslot < 0) begin
                  freeslot = i;
               end
            end
            if (q.arrive_dest != endpoint) begin
               r.error_code = wnni_pkg::ERR_MISROUTE;
               outs.insert(outs.size(), r);
            end else if (eject_fill >= rbuf) begin
               r.error_code = wnni_pkg::ERR_EJECT;
               outs.insert(outs.size(), r);
            end else if (q.arrive_head && (found >= 0 || (!q.arrive_tail && freeslot < 0)))
            begin
               r.error_code = wnni_pkg::ERR_HEAD;
               outs.insert(outs.size(), r);
            end else if (q.arrive_tail && !q.arrive_head && found < 0) begin
               r.error_code = wnni_pkg::ERR_ORPHAN;
               outs.insert(outs.size(), r);
            end else if (q.arrive_tail && dlv_q.size() >= wnni_pkg::DELIVERY_DEPTH) begin
               r.error_code = wnni_pkg::ERR_EJECT;
               outs.insert(outs.size(), r);
            end else begin
               eject_fill++;
               if (q.arrive_head && !q.arrive_tail) begin
                  asm_valid[freeslot] = 1;
                  asm_pid[freeslot] = q.arrive_packet_id;
                  asm_tag[freeslot] = q.packet_tag;
               end
               if (q.arrive_tail) begin
                  if (q.arrive_head) begin
                     d.tag = q.packet_tag;
                  end else begin
                     d.tag = asm_tag[found];
                     asm_valid[found] = 0;
                  end
                  d.flits = q.arrive_flit_total;
                  dlv_q.insert(dlv_q.size(), d);
               end
            end
         end
         wnni_pkg::MODE_POP: begin
            if (q.virtual_net != 0 || dlv_q.size() == 0) begin
               outs.insert(outs.size(), blank(wnni_pkg::KIND_EMPTY));
            end else if (dlv_q[0].flits > eject_fill) begin
               r = blank(wnni_pkg::KIND_ERR);
               r.error_code = wnni_pkg::ERR_OCCUPY;
               outs.insert(outs.size(), r);
            end else begin
               d = dlv_q[0];
               dlv_q.delete(0);
               eject_fill -= d.flits;
               r = blank(wnni_pkg::KIND_CRED);
               r.credit_return = d.flits;
               outs.insert(outs.size(), r);
               r = blank(wnni_pkg::KIND_DLV);
               r.out_tag = d.tag;
               outs.insert(outs.size(), r);
            end
         end
         default: ;
      endcase
      if (outs.size() > 0) outs[outs.size() - 1].last = 1;
      foreach (outs[i]) push(outs[i]);
   endfunction

   function void check_result(wnni_pkg::rsp_type a);
      wnni_pkg::rsp_type x;
      if (pending.size() == 0) begin
         $error("unexpected result kind %0d", a.kind);
         errors++;
         return;
      end
      x = pending[0];
      pending.delete(0);
      if (a !== x) begin
         errors++;
         if (a.kind !== x.kind) $error("kind exp %0d got %0d", x.kind, a.kind);
         if (a.accepted !== x.accepted)
            $error("accepted exp %0d got %0d", x.accepted, a.accepted);
         if (a.out_packet_id !== x.out_packet_id)
            $error("out_packet_id exp %0d got %0d", x.out_packet_id, a.out_packet_id);
         if (a.out_source !== x.out_source)
            $error("out_source exp %0d got %0d", x.out_source, a.out_source);
         if (a.out_dest !== x.out_dest)
            $error("out_dest exp %0d got %0d", x.out_dest, a.out_dest);
         if (a.out_flit_index !== x.out_flit_index)
            $error("out_flit_index exp %0d got %0d", x.out_flit_index, a.out_flit_index);
         if (a.out_flit_total !== x.out_flit_total)
            $error("out_flit_total exp %0d got %0d", x.out_flit_total, a.out_flit_total);
         if (a.out_tag !== x.out_tag) $error("out_tag exp %0d got %0d", x.out_tag, a.out_tag);
         if (a.credit_return !== x.credit_return)
            $error("credit_return exp %0d got %0d", x.credit_return, a.credit_return);
         if (a.error_code !== x.error_code)
            $error("error_code exp %0d got %0d", x.error_code, a.error_code);
         if (a.last !== x.last) $error("last exp %0d got %0d", x.last, a.last);
      end
   endfunction
endclass

module tb_wormhole_noc_network_interface;
   import wnni_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   logic    csr_write = 0;
   logic [2:0] csr_index = '0;
   logic [8:0] csr_data = '0;

   int send_idle = 0;
   int recv_idle = 0;
   wnni_scoreboard board = new();
   bit [15:0] recent_pids[$];

   wormhole_noc_network_interface DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic write_reg(bit [2:0] idx, bit [8:0] val);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      board.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_item(req_type q);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(q);
   endtask

   function automatic req_type make_send(bit [8:0] dst, bit [11:0] bits, bit [1:0] vn);
      req_type q;
      q = '0;
      q.mode = MODE_SEND;
      q.dest_node = dst;
      q.size_bits = bits;
      q.virtual_net = vn;
      q.packet_tag = 16'($urandom);
      return q;
   endfunction

   function automatic req_type make_flit(bit [15:0] pid, bit [7:0] dst, bit hd, bit tl,
                                         bit [6:0] tot);
      req_type q;
      q = '0;
      q.mode = MODE_FLIT;
      q.arrive_packet_id = pid;
      q.arrive_dest = dst;
      q.arrive_head = hd;
      q.arrive_tail = tl;
      q.arrive_flit_total = tot;
      q.packet_tag = 16'($urandom);
      return q;
   endfunction

   function automatic req_type make_simple(bit [2:0] m);
      req_type q;
      q = '0;
      q.mode = m;
      return q;
   endfunction

   function automatic req_type random_item();
      req_type q;
      int pick;
      bit [15:0] pid;
      pick = $urandom_range(99);
      q = '0;
      q.dest_node = 9'($urandom);
      q.size_bits = 12'($urandom);
      q.virtual_net = 2'($urandom);
      q.arrive_packet_id = 16'($urandom);
      q.arrive_dest = 8'($urandom);
      q.packet_tag = 16'($urandom);
      if (pick < 25) begin
         q = make_send(9'($urandom_range(board.net_size)), 12'($urandom_range(300)),
                       ($urandom_range(9) == 0) ? 2'($urandom) : 2'd0);
         if ($urandom_range(9) == 0) q.size_bits = 12'($urandom);
         if ($urandom_range(19) == 0) q.dest_node = 9'($urandom);
      end else if (pick < 45) begin
         q = make_simple(MODE_TICK);
      end else if (pick < 52) begin
         q.mode = MODE_CREDIT;
         q.credit_count = 7'($urandom_range(3));
         if ($urandom_range(9) == 0) q.credit_count = 7'($urandom_range(64));
      end else if (pick < 80) begin
         if (recent_pids.size() != 0 && $urandom_range(1)) begin
            pid = recent_pids[$urandom_range(recent_pids.size() - 1)];
         end else begin
            pid = 16'($urandom_range(7));
         end
         q = make_flit(pid, board.endpoint, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       7'($urandom_range(1, 4)));
         if ($urandom_range(19) == 0) q.arrive_dest = 8'($urandom);
         if ($urandom_range(19) == 0) q.arrive_flit_total = 7'($urandom);
         if (q.arrive_head) recent_pids.insert(recent_pids.size(), pid);
         if (recent_pids.size() > 6) recent_pids.delete(0);
      end else if (pick < 97) begin
         q = make_simple(MODE_POP);
         if ($urandom_range(9) == 0) q.virtual_net = 2'($urandom);
      end else begin
         q.mode = 3'($urandom_range(5, 7));
      end
      return q;
   endfunction

   task automatic random_phase(int n);
      repeat (n) send_item(random_item());
   endtask

   initial begin
      req_type q;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: disabled send, then extremes of every mode
      send_item(make_send(9'd0, 12'd32, 2'd0));
      write_reg(REG_ENDPOINT, 9'd5);
      write_reg(REG_NETSIZE, 9'd256);
      write_reg(REG_FPC, 9'd8);
      write_reg(REG_RBUF, 9'd64);
      write_reg(REG_IBUF, 9'd64);
      write_reg(REG_ENABLE, 9'd1);
      send_item(make_send(9'd511, 12'd64, 2'd0));
      send_item(make_send(9'd255, 12'd4095, 2'd0));
      send_item(make_send(9'd3, 12'd2048, 2'd0));
      send_item(make_send(9'd3, 12'd0, 2'd0));
      send_item(make_send(9'd3, 12'd33, 2'd3));
      send_item(make_simple(MODE_TICK));
      q = make_simple(MODE_CREDIT);
      q.credit_count = 7'd64;
      send_item(q);
      q.credit_count = 7'd1;
      send_item(q);
      send_item(make_flit(16'hffff, 8'd6, 1'b1, 1'b1, 7'd1));
      send_item(make_flit(16'h1, 8'd5, 1'b0, 1'b1, 7'd2));
      send_item(make_flit(16'h1, 8'd5, 1'b1, 1'b0, 7'd2));
      send_item(make_flit(16'h1, 8'd5, 1'b1, 1'b0, 7'd2));
      send_item(make_flit(16'h1, 8'd5, 1'b0, 1'b0, 7'd2));
      send_item(make_flit(16'h1, 8'd5, 1'b0, 1'b1, 7'd3));
      send_item(make_flit(16'hffff, 8'd5, 1'b1, 1'b1, 7'd64));
      send_item(make_simple(MODE_POP));
      send_item(make_simple(MODE_POP));
      send_item(make_simple(MODE_POP));
      q = make_simple(MODE_POP);
      q.virtual_net = 2'd2;
      send_item(q);
      q = '1;
      send_item(q);
      drain();

      // small buffers, narrow link
      write_reg(REG_RBUF, 9'd1);
      write_reg(REG_IBUF, 9'd1);
      write_reg(REG_FPC, 9'd1);
      write_reg(REG_ENDPOINT, 9'd255);
      write_reg(REG_NETSIZE, 9'd1);
      send_item(make_send(9'd0, 12'd32, 2'd0));
      send_item(make_send(9'd0, 12'd33, 2'd0));
      send_item(make_flit(16'h2, 8'd255, 1'b1, 1'b0, 7'd2));
      send_item(make_flit(16'h3, 8'd255, 1'b1, 1'b1, 7'd1));
      drain();

      send_idle = 30;
      recv_idle = 59;
      write_reg(REG_RBUF, 9'd8);
      write_reg(REG_IBUF, 9'd24);
      write_reg(REG_FPC, 9'd3);
      write_reg(REG_ENDPOINT, 9'd0);
      write_reg(REG_NETSIZE, 9'd4);
      random_phase(30);
      drain();

      send_idle = 59;
      recv_idle = 30;
      write_reg(REG_RBUF, 9'd32);
      write_reg(REG_IBUF, 9'd64);
      write_reg(REG_FPC, 9'd15);
      write_reg(REG_ENDPOINT, 9'd17);
      write_reg(REG_NETSIZE, 9'd40);
      random_phase(28);
      drain();

      send_idle = 0;
      recv_idle = 0;
      write_reg(REG_FPC, 9'd0);
      send_item(make_send(9'd1, 12'd40, 2'd0));
      send_item(make_simple(MODE_TICK));
      drain();
      write_reg(REG_FPC, 9'd2);
      write_reg(REG_ENABLE, 9'd0);
      random_phase(10);
      drain();
      write_reg(REG_ENABLE, 9'd1);
      random_phase(20);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (board.pending.size() != 0) $error("%0d results never came", board.pending.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

@@ filelist.f @@
src/wnni_pkg.sv
src/wnni_ram.sv
src/wormhole_noc_network_interface.sv
tb/tb_wormhole_noc_network_interface.sv
